@@ rtl/rcdc_pkg.sv @@
// ---------------------------------------------------------------------------
// rcdc_pkg
// Shared types and constants of the rgb 3x3 convolution filter.
// ---------------------------------------------------------------------------
package rcdc_pkg;

   localparam int PIX_W      = 24;
   localparam int CH_W       = 8;
   localparam int NUM_CH     = 3;
   localparam int TAPS       = 9;
   localparam int PROD_W     = 17;
   localparam int ACC_W      = 21;
   localparam int NUM_W      = 15;
   localparam int DIV_STEPS  = 15;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;
   localparam int DIVISOR_W  = 15;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 13;
   localparam int ROW_W      = 12;
   localparam int MAX_HEIGHT = 4096;
   localparam int MIN_SIZE   = 3;

   localparam logic [CSR_ADDR_W-1:0] REG_COEF_TOP = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_COEF_MID = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_COEF_BOT = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_DIVISOR  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_WIDTH    = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_HEIGHT   = 3'd5;

   localparam logic [CH_W-1:0] CLAMP_MAX = 8'd255;

   typedef struct packed {
      logic mul;
      logic sum;
      logic div;
   } lane_ctl_type;

endpackage

@@ rtl/rcdc_lane.sv @@
// ---------------------------------------------------------------------------
// rcdc_lane
// One colour channel: nine products, 16-bit wrapped sum, restoring divide
// and clamp to 0..255.
// ---------------------------------------------------------------------------
module rcdc_lane (
   input  logic                                        clock,
   input  rcdc_pkg::lane_ctl_type                      ctl,
   input  logic [rcdc_pkg::TAPS-1:0][rcdc_pkg::CH_W-1:0] pix,
   input  logic [rcdc_pkg::TAPS-1:0][rcdc_pkg::CH_W-1:0] coef,
   input  logic [rcdc_pkg::DIVISOR_W-1:0]              divisor,
   output logic [rcdc_pkg::CH_W-1:0]                   result
);

   logic signed [rcdc_pkg::PROD_W-1:0] prod_ff [rcdc_pkg::TAPS];
   logic signed [rcdc_pkg::ACC_W-1:0]  acc;
   logic [rcdc_pkg::NUM_W:0]           rem_ff, rem_in, rem_sh;
   logic [rcdc_pkg::NUM_W-1:0]         quo_ff, quo_in;
   logic                               neg_ff, neg_in;

   always_ff @(posedge clock) begin
      if (ctl.mul) begin
         for (int k = 0; k < rcdc_pkg::TAPS; k++) begin
            prod_ff[k] <= $signed({1'b0, pix[k]}) * $signed(coef[k]);
         end
      end
   end

   always_comb begin
      acc = '0;
      for (int k = 0; k < rcdc_pkg::TAPS; k++) begin
         acc = acc + rcdc_pkg::ACC_W'(prod_ff[k]);
      end
   end

   // negative sums always clamp to zero, so only the low 15 bits of the sum are divided
   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      neg_in = neg_ff;
      rem_sh = {rem_ff[rcdc_pkg::NUM_W-1:0], quo_ff[rcdc_pkg::NUM_W-1]};
      if (ctl.sum) begin
         neg_in = acc[15];
         quo_in = acc[rcdc_pkg::NUM_W-1:0];
         rem_in = '0;
      end else if (ctl.div) begin
         if (rem_sh >= {1'b0, divisor}) begin
            rem_in = rem_sh - {1'b0, divisor};
            quo_in = {quo_ff[rcdc_pkg::NUM_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[rcdc_pkg::NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      if (neg_ff) begin
         result = '0;
      end else if (|quo_ff[rcdc_pkg::NUM_W-1:rcdc_pkg::CH_W]) begin
         result = rcdc_pkg::CLAMP_MAX;
      end else begin
         result = quo_ff[rcdc_pkg::CH_W-1:0];
      end
   end

endmodule

@@ rtl/rcdc_merge.sv @@
// ---------------------------------------------------------------------------
// rcdc_merge
// Gathers the three lane results into one output register.
// ---------------------------------------------------------------------------
module rcdc_merge (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              load,
   input  logic [rcdc_pkg::NUM_CH-1:0][rcdc_pkg::CH_W-1:0]   lane_result,
   input  logic                                              frame_end,
   output logic                                              load_ok,
   output logic                                              rsp_tvalid,
   input  logic                                              rsp_tready,
   output logic [rcdc_pkg::PIX_W-1:0]                        rsp_tdata,
   output logic                                              rsp_tlast
);

   logic                        valid_ff, valid_in;
   logic [rcdc_pkg::PIX_W-1:0]  data_ff;
   logic                        last_ff;

   assign load_ok = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= {lane_result[2], lane_result[1], lane_result[0]};
         last_ff <= frame_end;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

@@ rtl/rgb_conv3x3_divide_clamp_top.sv @@
// ---------------------------------------------------------------------------
// rgb_conv3x3_divide_clamp_top
// 3x3 convolution on an rgb raster stream, divided and clamped per channel.
// ---------------------------------------------------------------------------
// channel  | direction | contents
// req_*    | in        | tdata: red_in, green_in, blue_in
// rsp_*    | out       | tdata: red_out, green_out, blue_out; tlast: frame_end
// csr_*    | in        | register write: index, data
//
// A border pixel passes accept and line store read only; an interior pixel
// passes accept, line store read, products, sum, 15 steps of the restoring
// divider (one in each of the three parallel lanes) and output load.
// Synchronous reset clears counters, window, state, output valid; sets CSR defaults.
// A full output register holds the finished item until rsp_tready.
// ---------------------------------------------------------------------------
module rgb_conv3x3_divide_clamp_top #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [rcdc_pkg::PIX_W-1:0]          req_tdata,  // red, green, blue
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [rcdc_pkg::PIX_W-1:0]          rsp_tdata,  // red, green, blue
   output logic                                rsp_tlast,  // frame_end
   input  logic                                csr_wr_en,
   input  logic [rcdc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [rcdc_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int CW  = $clog2(MAX_WIDTH);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int EW  = (WW > rcdc_pkg::WIDTH_W) ? WW : rcdc_pkg::WIDTH_W;
   localparam int HW  = rcdc_pkg::HEIGHT_W;
   localparam int DCW = $clog2(rcdc_pkg::DIV_STEPS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_MUL  = 3'd2;
   localparam logic [2:0] S_SUM  = 3'd3;
   localparam logic [2:0] S_DIV  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   // configuration
   logic [23:0] coef_top_ff, coef_mid_ff, coef_bot_ff;
   logic [rcdc_pkg::DIVISOR_W-1:0] divisor_ff;
   logic [rcdc_pkg::WIDTH_W-1:0]   width_ff;
   logic [rcdc_pkg::HEIGHT_W-1:0]  height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_top_ff <= '0;
         coef_mid_ff <= 24'h010000;
         coef_bot_ff <= '0;
         divisor_ff  <= rcdc_pkg::DIVISOR_W'(1);
         width_ff    <= rcdc_pkg::WIDTH_W'(1024);
         height_ff   <= rcdc_pkg::HEIGHT_W'(1024);
      end else if (csr_wr_en) begin
         case (csr_addr)
            rcdc_pkg::REG_COEF_TOP: coef_top_ff <= csr_wr_data;
            rcdc_pkg::REG_COEF_MID: coef_mid_ff <= csr_wr_data;
            rcdc_pkg::REG_COEF_BOT: coef_bot_ff <= csr_wr_data;
            rcdc_pkg::REG_DIVISOR:  divisor_ff  <= csr_wr_data[rcdc_pkg::DIVISOR_W-1:0];
            rcdc_pkg::REG_WIDTH:    width_ff    <= csr_wr_data[rcdc_pkg::WIDTH_W-1:0];
            rcdc_pkg::REG_HEIGHT:   height_ff   <= csr_wr_data[rcdc_pkg::HEIGHT_W-1:0];
            default: ;
         endcase
      end
   end

   logic [EW-1:0] w_ext, w_eff;
   logic [HW-1:0] h_eff;
   logic [rcdc_pkg::DIVISOR_W-1:0] div_eff;

   always_comb begin
      w_ext = EW'(width_ff);
      if (w_ext < EW'(rcdc_pkg::MIN_SIZE)) begin
         w_eff = EW'(rcdc_pkg::MIN_SIZE);
      end else if (w_ext > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
      if (height_ff < HW'(rcdc_pkg::MIN_SIZE)) begin
         h_eff = HW'(rcdc_pkg::MIN_SIZE);
      end else if (height_ff > HW'(rcdc_pkg::MAX_HEIGHT)) begin
         h_eff = HW'(rcdc_pkg::MAX_HEIGHT);
      end else begin
         h_eff = height_ff;
      end
      div_eff = (divisor_ff == '0) ? rcdc_pkg::DIVISOR_W'(1) : divisor_ff;
   end

   // raster position
   logic [2:0]                  state_ff, state_in;
   logic [CW-1:0]               col_ff, col_in, c0;
   logic [rcdc_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [HW-1:0]               r0, r1;
   logic [EW-1:0]               c1;
   logic                        accept, produce, last_px;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      c0 = col_ff;
      r0 = HW'(row_ff);
      if (EW'(col_ff) >= w_eff) begin
         c0 = '0;
         r0 = HW'(row_ff) + HW'(1);
      end
      if (r0 >= h_eff) begin
         r0 = '0;
      end
      produce = (r0 >= HW'(2)) && (c0 >= CW'(2));
      last_px = (r0 == h_eff - HW'(1)) && (EW'(c0) == w_eff - EW'(1));
      c1 = EW'(c0) + EW'(1);
      r1 = r0;
      if (c1 >= w_eff) begin
         c1 = '0;
         r1 = r0 + HW'(1);
         if (r1 >= h_eff) begin
            r1 = '0;
         end
      end
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         col_in = c1[CW-1:0];
         row_in = r1[rcdc_pkg::ROW_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // item registers
   logic [CW-1:0]              addr_ff;
   logic [rcdc_pkg::PIX_W-1:0] pix_ff;
   logic                       produce_ff, last_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff    <= c0;
         pix_ff     <= req_tdata;
         produce_ff <= produce;
         last_ff    <= last_px;
      end
   end

   // line store: one word per column, previous-previous row above previous row
   logic [2*rcdc_pkg::PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*rcdc_pkg::PIX_W-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[c0];
      end
      if (state_ff == S_READ) begin
         line_mem[addr_ff] <= {rd_ff[rcdc_pkg::PIX_W-1:0], pix_ff};
      end
   end

   // 3x3 window, index row*3 + column
   logic [rcdc_pkg::PIX_W-1:0] win_ff [rcdc_pkg::TAPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < rcdc_pkg::TAPS; k++) begin
            win_ff[k] <= '0;
         end
      end else if (state_ff == S_READ) begin
         for (int k = 0; k < 3; k++) begin
            win_ff[k*3]   <= win_ff[k*3+1];
            win_ff[k*3+1] <= win_ff[k*3+2];
         end
         win_ff[2] <= rd_ff[2*rcdc_pkg::PIX_W-1:rcdc_pkg::PIX_W];
         win_ff[5] <= rd_ff[rcdc_pkg::PIX_W-1:0];
         win_ff[8] <= pix_ff;
      end
   end

   // sequencer
   logic [DCW-1:0]          step_ff, step_in;
   logic                    load_ok, load;
   rcdc_pkg::lane_ctl_type  lane_ctl;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      load     = 1'b0;
      lane_ctl = '0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = produce_ff ? S_MUL : S_IDLE;
         end
         S_MUL: begin
            lane_ctl.mul = 1'b1;
            state_in = S_SUM;
         end
         S_SUM: begin
            lane_ctl.sum = 1'b1;
            step_in  = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            lane_ctl.div = 1'b1;
            step_in = step_ff + DCW'(1);
            if (step_ff == DCW'(rcdc_pkg::DIV_STEPS - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (load_ok) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // lanes
   logic [rcdc_pkg::TAPS-1:0][rcdc_pkg::CH_W-1:0] coef;
   logic [rcdc_pkg::NUM_CH-1:0][rcdc_pkg::CH_W-1:0] lane_result;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         coef[c]   = coef_top_ff[c*rcdc_pkg::CH_W +: rcdc_pkg::CH_W];
         coef[3+c] = coef_mid_ff[c*rcdc_pkg::CH_W +: rcdc_pkg::CH_W];
         coef[6+c] = coef_bot_ff[c*rcdc_pkg::CH_W +: rcdc_pkg::CH_W];
      end
   end

   for (genvar ch = 0; ch < rcdc_pkg::NUM_CH; ch++) begin : g_lane
      logic [rcdc_pkg::TAPS-1:0][rcdc_pkg::CH_W-1:0] lane_pix;

      always_comb begin
         for (int k = 0; k < rcdc_pkg::TAPS; k++) begin
            lane_pix[k] = win_ff[k][ch*rcdc_pkg::CH_W +: rcdc_pkg::CH_W];
         end
      end

      rcdc_lane u_lane (
         .clock   (clock),
         .ctl     (lane_ctl),
         .pix     (lane_pix),
         .coef    (coef),
         .divisor (div_eff),
         .result  (lane_result[ch])
      );
   end

   rcdc_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .load        (load),
      .lane_result (lane_result),
      .frame_end   (last_ff),
      .load_ok     (load_ok),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

@@ rtl/rcdc_checker.sv @@
// ---------------------------------------------------------------------------
// rcdc_checker
// Port-level checks of the filter top level, bound to every instance.
// ---------------------------------------------------------------------------
module rcdc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [rcdc_pkg::PIX_W-1:0]    rsp_tdata,
   input logic                          rsp_tlast
);

   // a stalled result stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // one pixel at a time: no transfer in the cycle after an input transfer
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while previous pixel still in work");

   // rsp_tvalid does not rise while the pixel just accepted is in its line store read
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("result appeared too early");

   assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind rgb_conv3x3_divide_clamp_top rcdc_checker u_rcdc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
